>>> rtl/sgb_pkg.sv
// sgb_pkg: shared types and constants of the spatial grid bucket index
// word layouts, job codes, sequencer states, register indexes
// no dependencies
package sgb_pkg;

    localparam int POINTS = 64;
    localparam int PTR_W  = 6;
    localparam int LINK_W = 7;
    localparam int COLS   = 16;
    localparam int ROWS   = 16;
    localparam int COL_W  = 4;
    localparam int ROW_W  = 4;
    localparam int CELLS  = COLS * ROWS;
    localparam int CELL_W = COL_W + ROW_W;

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_MOVE  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam logic [2:0] CFG_MIN_X   = 3'd0;
    localparam logic [2:0] CFG_MAX_X   = 3'd1;
    localparam logic [2:0] CFG_WIDTH_X = 3'd2;
    localparam logic [2:0] CFG_MIN_Y   = 3'd3;
    localparam logic [2:0] CFG_MAX_Y   = 3'd4;
    localparam logic [2:0] CFG_WIDTH_Y = 3'd5;
    localparam logic [2:0] CFG_CELLS_X = 3'd6;
    localparam logic [2:0] CFG_CELLS_Y = 3'd7;

    typedef struct packed {
        logic [1:0]         kind;
        logic [5:0]         element;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic [30:0]        radius;
    } t_in;

    typedef struct packed {
        logic [5:0] neighbor;
        logic       found;
        logic [3:0] cell_col;
        logic [3:0] cell_row;
        logic       last;
    } t_out;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_MOVE,
        OP_QUERY
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [PTR_W-1:0]   element;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic [30:0]        radius;
    } t_job;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RDPOS,
        ST_OCELL,
        ST_UNLINK,
        ST_NCELL,
        ST_HRD,
        ST_LINK,
        ST_LINK2,
        ST_RES,
        ST_QCELL,
        ST_RSQ,
        ST_NBSEL,
        ST_HEAD,
        ST_WALK,
        ST_PRD,
        ST_PWAIT,
        ST_M1,
        ST_M2,
        ST_CMP,
        ST_QEND
    } t_state;

    function automatic logic [3:0] cell_last(input logic [4:0] n, input logic [4:0] lim);
        logic [3:0] r;
        if (n == 5'd0) begin
            r = 4'd0;
        end else if (n > lim) begin
            r = 4'(lim - 5'd1);
        end else begin
            r = 4'(n - 5'd1);
        end
        return r;
    endfunction

endpackage

>>> rtl/spatial_grid_bucket_index.sv
// spatial_grid_bucket_index: uniform 2D grid with per-cell linked point lists
// depends on sgb_pkg, sgb_front, sgb_engine, sgb_cellq, sgb_outq
//
//  port group     dir  handshake              word
//  input items    in   push / full            i_item (t_in)
//  results        out  empty / pop            o_result (t_out)
//  registers      in   i_cfg_valid / ready    i_cfg_index, i_cfg_data
//
// add and move are both set by the two cell index units: add uses them once,
// move twice, for the old and the new position. query walks its own cell and
// the neighbor cells, skips cells off the grid, and tests the listed points,
// one position memory read a time.
// reset clears the head valid bits at once; no clearing pass.
// a two-word input queue and a two-word result queue let either side stall.
module spatial_grid_bucket_index (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  sgb_pkg::t_in  i_item,
    output logic          empty,
    input  logic          pop,
    output sgb_pkg::t_out o_result,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);
    import sgb_pkg::*;

    logic job_valid, job_take;
    t_job job;
    logic res_push, res_full;
    t_out res_word;

    sgb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .o_valid (job_valid),
        .o_job   (job),
        .i_take  (job_take)
    );

    sgb_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_take      (job_take),
        .o_push      (res_push),
        .o_word      (res_word),
        .i_full      (res_full)
    );

    sgb_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (res_push),
        .i_word   (res_word),
        .o_full   (res_full),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result written into a full queue");

    a_miss_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.found) |-> (o_result.last && o_result.neighbor == 6'd0))
        else $error("empty result word not marked last");

    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_take |-> job_valid)
        else $error("job taken from empty input queue");

endmodule

>>> rtl/sgb_front.sv
// sgb_front: input word queue, decodes the kind and drops unknown kinds
// depends on sgb_pkg
module sgb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  sgb_pkg::t_in  i_item,
    output logic          o_valid,
    output sgb_pkg::t_job o_job,
    input  logic          i_take
);
    import sgb_pkg::*;

    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       keep;
    logic       wr;
    logic       rd;
    t_job       job_in;

    always_comb begin
        job_in.element = i_item.element;
        job_in.coord_x = i_item.coord_x;
        job_in.coord_y = i_item.coord_y;
        job_in.radius  = i_item.radius;
        keep = 1'b1;
        case (i_item.kind)
            KIND_ADD:   job_in.op = OP_ADD;
            KIND_MOVE:  job_in.op = OP_MOVE;
            KIND_QUERY: job_in.op = OP_QUERY;
            default: begin
                job_in.op = OP_ADD;
                keep = 1'b0;
            end
        endcase
    end

    assign full    = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_q[r_rp];
    assign wr      = push && !full && keep;
    assign rd      = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= ~r_wp;
            end
            if (rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= job_in;
        end
    end

endmodule

>>> rtl/sgb_outq.sv
// sgb_outq: two-word result queue between the sequencer and the result port
// depends on sgb_pkg
module sgb_outq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sgb_pkg::t_out i_word,
    output logic          o_full,
    output logic          empty,
    input  logic          pop,
    output sgb_pkg::t_out o_result
);
    import sgb_pkg::*;

    t_out       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_full   = (r_cnt == 2'd2);
    assign empty    = (r_cnt == 2'd0);
    assign o_result = r_q[r_rp];
    assign wr       = i_push && !o_full;
    assign rd       = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= ~r_wp;
            end
            if (rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= i_word;
        end
    end

endmodule

>>> rtl/sgb_cellq.sv
// sgb_cellq: cell index along one axis, clamped, quotient one bit a cycle
// depends on sgb_pkg
module sgb_cellq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_coord,
    input  logic signed [31:0] i_lo,
    input  logic signed [31:0] i_hi,
    input  logic [30:0]        i_width,
    input  logic [3:0]         i_last,
    output logic               o_done,
    output logic [3:0]         o_cell
);
    import sgb_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [2:0]  r_cnt;
    logic [31:0] r_rem;
    logic [30:0] r_w;
    logic [3:0]  r_q;
    logic [3:0]  r_last;
    logic        r_le, r_ge, r_sat;
    logic [32:0] diff;
    logic [34:0] wsh;
    logic        fits;

    assign diff = {i_coord[31], i_coord} - {i_lo[31], i_lo};
    assign wsh  = {4'b0, r_w} << r_cnt;
    assign fits = ({3'b0, r_rem} >= wsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd4;
            end else if (r_busy) begin
                if (r_cnt == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= diff[31:0];
            r_w    <= (i_width == 31'd0) ? 31'd1 : i_width;
            r_q    <= 4'd0;
            r_last <= i_last;
            r_le   <= (i_coord <= i_lo);
            r_ge   <= (i_coord >= i_hi);
            r_sat  <= 1'b0;
        end else if (r_busy && fits) begin
            if (r_cnt == 3'd4) begin
                r_sat <= 1'b1;
            end else begin
                r_rem        <= r_rem - wsh[31:0];
                r_q[r_cnt[1:0]] <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_cell = r_le ? 4'd0 :
                    (r_ge || r_sat || (r_q > r_last)) ? r_last : r_q;

endmodule

>>> rtl/sgb_engine.sv
// sgb_engine: sequencer for add, move and query over the grid lists
// holds position, link and cell head memories; depends on sgb_pkg, sgb_cellq
module sgb_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    input  logic          i_job_valid,
    input  sgb_pkg::t_job i_job,
    output logic          o_take,
    output logic          o_push,
    output sgb_pkg::t_out o_word,
    input  logic          i_full
);
    import sgb_pkg::*;

    localparam logic [3:0] NB_END   = 4'd9;
    localparam logic [6:0] WALK_MAX = 7'(POINTS);
    localparam logic [6:0] HIT_MAX  = 7'd64;

    t_state r_state, n_state;

    logic signed [31:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic [30:0]        r_wid_x, r_wid_y;
    logic [4:0]         r_cells_x, r_cells_y;
    logic [3:0]         last_c, last_r;

    logic signed [31:0] pos_x_mem [POINTS];
    logic signed [31:0] pos_y_mem [POINTS];
    logic [LINK_W-1:0]  ln_mem [POINTS];
    logic [LINK_W-1:0]  lp_mem [POINTS];
    logic [LINK_W-1:0]  head_mem [CELLS];
    logic [CELLS-1:0]   r_hv;

    logic signed [31:0] r_pxq, r_pyq;
    logic [LINK_W-1:0]  r_lnq, r_lpq, r_hdq;
    logic               r_hvq;

    t_job               r_job;
    logic signed [31:0] r_ox, r_oy, r_nx, r_ny;
    logic [LINK_W-1:0]  r_p, r_n, r_act;
    logic [3:0]         r_ocol, r_orow, r_col, r_row, r_hcol, r_hrow;
    logic [3:0]         r_nb;
    logic [61:0]        r_rsq, r_sqx, r_sqy;
    logic [30:0]        r_ax, r_ay;
    logic               r_far;
    logic [PTR_W-1:0]   r_cand, r_pend;
    logic               r_pend_v;
    logic [6:0]         r_steps, r_hits;

    logic               cell_start;
    logic signed [31:0] cell_cx, cell_cy;
    logic               done_x, done_y;
    logic               cell_done;
    logic [3:0]         cell_c, cell_r;

    logic [PTR_W-1:0]   rd_addr;
    logic [CELL_W-1:0]  hd_ra;
    logic               ln_we, lp_we, hd_we, pos_we;
    logic [PTR_W-1:0]   ln_wa, lp_wa;
    logic [LINK_W-1:0]  ln_wd, lp_wd, hd_wd;
    logic [CELL_W-1:0]  hd_wa;
    logic [LINK_W-1:0]  first;
    logic [LINK_W-1:0]  e_link;

    logic [30:0]        mul_a;
    logic [61:0]        prod;
    logic signed [32:0] sum_x, sum_y, dx, dy;
    logic [32:0]        ax, ay;
    logic [62:0]        sq_sum;
    logic               hit;
    logic               nb_ok;
    logic [3:0]         nb_c, nb_r;

    assign o_cfg_ready = 1'b1;
    assign last_c = cell_last(r_cells_x, 5'(COLS));
    assign last_r = cell_last(r_cells_y, 5'(ROWS));
    assign first  = r_hvq ? r_hdq : '0;
    assign e_link = {1'b0, r_job.element} + 7'd1;
    assign cell_done = done_x & done_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x   <= 32'sd0;
            r_max_x   <= 32'sd1048576;
            r_wid_x   <= 31'd65536;
            r_min_y   <= 32'sd0;
            r_max_y   <= 32'sd1048576;
            r_wid_y   <= 31'd65536;
            r_cells_x <= 5'd16;
            r_cells_y <= 5'd16;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_X:   r_min_x   <= i_cfg_data;
                CFG_MAX_X:   r_max_x   <= i_cfg_data;
                CFG_WIDTH_X: r_wid_x   <= i_cfg_data[30:0];
                CFG_MIN_Y:   r_min_y   <= i_cfg_data;
                CFG_MAX_Y:   r_max_y   <= i_cfg_data;
                CFG_WIDTH_Y: r_wid_y   <= i_cfg_data[30:0];
                CFG_CELLS_X: r_cells_x <= i_cfg_data[4:0];
                CFG_CELLS_Y: r_cells_y <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    sgb_cellq u_cell_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cell_start),
        .i_coord (cell_cx),
        .i_lo    (r_min_x),
        .i_hi    (r_max_x),
        .i_width (r_wid_x),
        .i_last  (last_c),
        .o_done  (done_x),
        .o_cell  (cell_c)
    );

    sgb_cellq u_cell_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cell_start),
        .i_coord (cell_cy),
        .i_lo    (r_min_y),
        .i_hi    (r_max_y),
        .i_width (r_wid_y),
        .i_last  (last_r),
        .o_done  (done_y),
        .o_cell  (cell_r)
    );

    // datapath helpers
    assign sum_x  = {r_pxq[31], r_pxq} + {r_job.coord_x[31], r_job.coord_x};
    assign sum_y  = {r_pyq[31], r_pyq} + {r_job.coord_y[31], r_job.coord_y};
    assign dx     = {r_ox[31], r_ox} - {r_pxq[31], r_pxq};
    assign dy     = {r_oy[31], r_oy} - {r_pyq[31], r_pyq};
    assign ax     = dx[32] ? 33'(-dx) : 33'(dx);
    assign ay     = dy[32] ? 33'(-dy) : 33'(dy);
    assign prod   = {31'b0, mul_a} * {31'b0, mul_a};
    assign sq_sum = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign hit    = (sq_sum < {1'b0, r_rsq});

    always_comb begin
        nb_ok = 1'b0;
        nb_c  = r_col;
        nb_r  = r_row;
        case (r_nb)
            4'd0: nb_ok = 1'b1;
            4'd1: begin
                nb_ok = (r_col != 4'd0);
                nb_c  = r_col - 4'd1;
            end
            4'd2: begin
                nb_ok = (r_col != last_c);
                nb_c  = r_col + 4'd1;
            end
            4'd3: begin
                nb_ok = (r_row != 4'd0);
                nb_r  = r_row - 4'd1;
            end
            4'd4: begin
                nb_ok = (r_row != last_r);
                nb_r  = r_row + 4'd1;
            end
            4'd5: begin
                nb_ok = (r_col != 4'd0) && (r_row != 4'd0);
                nb_c  = r_col - 4'd1;
                nb_r  = r_row - 4'd1;
            end
            4'd6: begin
                nb_ok = (r_col != last_c) && (r_row != 4'd0);
                nb_c  = r_col + 4'd1;
                nb_r  = r_row - 4'd1;
            end
            4'd7: begin
                nb_ok = (r_col != 4'd0) && (r_row != last_r);
                nb_c  = r_col - 4'd1;
                nb_r  = r_row + 4'd1;
            end
            4'd8: begin
                nb_ok = (r_col != last_c) && (r_row != last_r);
                nb_c  = r_col + 4'd1;
                nb_r  = r_row + 4'd1;
            end
            default: nb_ok = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_state = (i_job.op == OP_ADD) ? ST_NCELL : ST_RDPOS;
                end
            end
            ST_RDPOS:  n_state = (r_job.op == OP_MOVE) ? ST_OCELL : ST_QCELL;
            ST_OCELL:  n_state = cell_done ? ST_UNLINK : ST_OCELL;
            ST_UNLINK: n_state = ST_NCELL;
            ST_NCELL:  n_state = cell_done ? ST_HRD : ST_NCELL;
            ST_HRD:    n_state = (r_job.op == OP_QUERY) ? ST_HEAD : ST_LINK;
            ST_LINK:   n_state = ST_LINK2;
            ST_LINK2:  n_state = ST_RES;
            ST_RES:    n_state = i_full ? ST_RES : ST_IDLE;
            ST_QCELL:  n_state = cell_done ? ST_RSQ : ST_QCELL;
            ST_RSQ:    n_state = ST_NBSEL;
            ST_NBSEL: begin
                if (r_nb == NB_END) begin
                    n_state = ST_QEND;
                end else if (nb_ok) begin
                    n_state = ST_HRD;
                end
            end
            ST_HEAD:   n_state = ST_WALK;
            ST_WALK: begin
                if ((r_act == '0) || (r_steps == WALK_MAX) || (r_hits == HIT_MAX)) begin
                    n_state = ST_NBSEL;
                end else begin
                    n_state = ST_PRD;
                end
            end
            ST_PRD:    n_state = ST_PWAIT;
            ST_PWAIT: begin
                if ((ax >= {2'b0, r_job.radius}) || (ay >= {2'b0, r_job.radius})) begin
                    n_state = ST_WALK;
                end else begin
                    n_state = ST_M1;
                end
            end
            ST_M1:     n_state = ST_M2;
            ST_M2:     n_state = ST_CMP;
            ST_CMP: begin
                if (!(hit && r_pend_v && i_full)) begin
                    n_state = ST_WALK;
                end
            end
            ST_QEND:   n_state = i_full ? ST_QEND : ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb begin
        o_take     = 1'b0;
        o_push     = 1'b0;
        o_word     = '0;
        cell_start = 1'b0;
        cell_cx    = r_nx;
        cell_cy    = r_ny;
        rd_addr    = r_job.element;
        hd_ra      = {r_hrow, r_hcol};
        ln_we      = 1'b0;
        ln_wa      = r_job.element;
        ln_wd      = first;
        lp_we      = 1'b0;
        lp_wa      = r_job.element;
        lp_wd      = '0;
        hd_we      = 1'b0;
        hd_wa      = {r_row, r_col};
        hd_wd      = e_link;
        pos_we     = 1'b0;
        mul_a      = r_ax;
        case (r_state)
            ST_IDLE: begin
                o_take  = i_job_valid;
                rd_addr = i_job.element;
                cell_cx = i_job.coord_x;
                cell_cy = i_job.coord_y;
                cell_start = i_job_valid && (i_job.op == OP_ADD);
            end
            ST_RDPOS: begin
                cell_cx    = r_pxq;
                cell_cy    = r_pyq;
                cell_start = 1'b1;
            end
            ST_UNLINK: begin
                cell_start = 1'b1;
                if (r_p != '0) begin
                    ln_we = 1'b1;
                    ln_wa = PTR_W'(r_p - 7'd1);
                    ln_wd = r_n;
                end else begin
                    hd_we = 1'b1;
                    hd_wa = {r_orow, r_ocol};
                    hd_wd = r_n;
                end
                if (r_n != '0) begin
                    lp_we = 1'b1;
                    lp_wa = PTR_W'(r_n - 7'd1);
                    lp_wd = r_p;
                end
            end
            ST_LINK: begin
                ln_we  = 1'b1;
                hd_we  = 1'b1;
                pos_we = 1'b1;
                if (first != '0) begin
                    lp_we = 1'b1;
                    lp_wa = PTR_W'(first - 7'd1);
                    lp_wd = e_link;
                end
            end
            ST_LINK2: lp_we = 1'b1;
            ST_RES: begin
                o_push          = !i_full;
                o_word.cell_col = r_col;
                o_word.cell_row = r_row;
                o_word.last     = 1'b1;
            end
            ST_RSQ:  mul_a   = r_job.radius;
            ST_PRD:  rd_addr = PTR_W'(r_act - 7'd1);
            ST_M1:   mul_a   = r_ax;
            ST_M2:   mul_a   = r_ay;
            ST_CMP: begin
                o_push          = hit && r_pend_v && !i_full;
                o_word.neighbor = r_pend;
                o_word.found    = 1'b1;
                o_word.cell_col = r_col;
                o_word.cell_row = r_row;
            end
            ST_QEND: begin
                o_push          = !i_full;
                o_word.neighbor = r_pend_v ? r_pend : '0;
                o_word.found    = r_pend_v;
                o_word.cell_col = r_col;
                o_word.cell_row = r_row;
                o_word.last     = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_hv     <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (hd_we) begin
                r_hv[hd_wa] <= 1'b1;
            end
            if (r_state == ST_RSQ) begin
                r_pend_v <= 1'b0;
            end else if (r_state == ST_CMP && n_state == ST_WALK && hit) begin
                r_pend_v <= 1'b1;
            end
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        r_pxq <= pos_x_mem[rd_addr];
        r_pyq <= pos_y_mem[rd_addr];
        r_lnq <= ln_mem[rd_addr];
        r_lpq <= lp_mem[rd_addr];
        r_hdq <= head_mem[hd_ra];
        r_hvq <= r_hv[hd_ra];
        if (pos_we) begin
            pos_x_mem[r_job.element] <= r_nx;
            pos_y_mem[r_job.element] <= r_ny;
        end
        if (ln_we) begin
            ln_mem[ln_wa] <= ln_wd;
        end
        if (lp_we) begin
            lp_mem[lp_wa] <= lp_wd;
        end
        if (hd_we) begin
            head_mem[hd_wa] <= hd_wd;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    r_job <= i_job;
                    r_nx  <= i_job.coord_x;
                    r_ny  <= i_job.coord_y;
                end
            end
            ST_RDPOS: begin
                r_ox <= r_pxq;
                r_oy <= r_pyq;
                r_p  <= r_lpq;
                r_n  <= r_lnq;
                if (sum_x[32] != sum_x[31]) begin
                    r_nx <= sum_x[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
                end else begin
                    r_nx <= sum_x[31:0];
                end
                if (sum_y[32] != sum_y[31]) begin
                    r_ny <= sum_y[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
                end else begin
                    r_ny <= sum_y[31:0];
                end
            end
            ST_OCELL: begin
                r_ocol <= cell_c;
                r_orow <= cell_r;
            end
            ST_NCELL, ST_QCELL: begin
                r_col  <= cell_c;
                r_row  <= cell_r;
                r_hcol <= cell_c;
                r_hrow <= cell_r;
            end
            ST_RSQ: begin
                r_rsq  <= prod;
                r_nb   <= 4'd0;
                r_hits <= 7'd0;
            end
            ST_NBSEL: begin
                if (r_nb != NB_END) begin
                    r_nb   <= r_nb + 4'd1;
                    r_hcol <= nb_c;
                    r_hrow <= nb_r;
                end
            end
            ST_HEAD: begin
                r_act   <= first;
                r_steps <= 7'd0;
            end
            ST_PRD: r_steps <= r_steps + 7'd1;
            ST_PWAIT: begin
                r_act  <= r_lnq;
                r_cand <= PTR_W'(r_act - 7'd1);
                r_ax   <= ax[30:0];
                r_ay   <= ay[30:0];
                r_far  <= (ax >= {2'b0, r_job.radius});
            end
            ST_M1: r_sqx <= prod;
            ST_M2: r_sqy <= prod;
            ST_CMP: begin
                if (hit && !(r_pend_v && i_full) && !r_far) begin
                    r_pend <= r_cand;
                    r_hits <= r_hits + 7'd1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
